/* rtl/core/sha1_pkg.sv */
`default_nettype none
package sha1_pkg;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned CountW    = 61;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam int unsigned IdxW      = $clog2(NumChain);

  localparam logic [31:0] H_INIT [NumChain] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [RoundW-1:0] LAST_ROUND = RoundW'(NumRounds - 1);
  localparam logic [IdxW-1:0]   LAST_IDX   = IdxW'(NumChain - 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic byte_wr;
    logic pad;
    logic len_blk;
    logic start;
    logic round;
    logic fold;
    logic emit_next;
    logic restart;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic blk_end;
    logic pad_two;
    logic last_round;
    logic last_word;
  } sta_t;

endpackage
`default_nettype wire

/* rtl/core/sha1_ctrl.sv */
`default_nettype none
module sha1_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_kind,
  input  wire                out_stall,
  input  sha1_pkg::sta_t     sta,
  output sha1_pkg::cmd_t     cmd,
  output logic               in_stall,
  output logic               out_valid
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;
  logic       extra_r, extra_nxt;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    extra_nxt = extra_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!in_kind) begin
            cmd.byte_wr = 1'b1;
            if (sta.blk_end) begin
              cmd.start = 1'b1;
              fin_nxt   = 1'b0;
              extra_nxt = 1'b0;
              state_nxt = ST_ROUND;
            end
          end else begin
            cmd.pad   = 1'b1;
            cmd.start = 1'b1;
            fin_nxt   = 1'b1;
            extra_nxt = sta.pad_two;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sta.last_round) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (extra_r) begin
          state_nxt = ST_LEN;
        end else if (fin_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LEN: begin
        // length-only block after a pad that spilled past the length field
        cmd.len_blk = 1'b1;
        cmd.start   = 1'b1;
        extra_nxt   = 1'b0;
        state_nxt   = ST_ROUND;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_next = 1'b1;
          if (sta.last_word) begin
            cmd.restart = 1'b1;
            fin_nxt     = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      extra_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      extra_r <= extra_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sha1_dp.sv */
`default_nettype none
module sha1_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  sha1_pkg::cmd_t     cmd,
  input  wire  [7:0]         in_data_byte,
  output sha1_pkg::sta_t     sta,
  output logic [31:0]        digest_word,
  output logic               last_word
);

  logic [31:0] w_r [sha1_pkg::NumWords];
  logic [31:0] w_fill [sha1_pkg::NumWords];
  logic [31:0] chain_r [sha1_pkg::NumChain];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [sha1_pkg::CountW-1:0] count_r;
  logic [sha1_pkg::RoundW-1:0] rnd_r;
  logic [sha1_pkg::IdxW-1:0]   idx_r;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [31:0] f_val, k_val, t_val, w_mix, w_new;
  logic        len_here;

  assign pos     = count_r[5:0];
  assign bit_len = {count_r, 3'b000};
  // length goes into this block unless the pad byte lands in the length field
  assign len_here = (cmd.pad && !(&pos[5:3])) || cmd.len_blk;

  assign sta.blk_end    = &pos;
  assign sta.pad_two    = &pos[5:3];
  assign sta.last_round = (rnd_r == sha1_pkg::LAST_ROUND);
  assign sta.last_word  = (idx_r == sha1_pkg::LAST_IDX);

  assign digest_word = chain_r[idx_r];
  assign last_word   = (idx_r == sha1_pkg::LAST_IDX);

  // byte write, padding and length fill of the block buffer
  always_comb begin
    logic [7:0] bval;
    logic [5:0] j;
    for (int i = 0; i < 16; i++) begin
      for (int b = 0; b < 4; b++) begin
        j    = 6'(4 * i + b);
        bval = w_r[i][8*(3-b) +: 8];
        if (cmd.byte_wr && (j == pos)) begin
          bval = in_data_byte;
        end
        if (cmd.pad) begin
          if (j == pos) begin
            bval = sha1_pkg::PAD_BYTE;
          end else if (j > pos) begin
            bval = 8'h00;
          end
        end
        if (cmd.len_blk) begin
          bval = 8'h00;
        end
        if (len_here && (4 * i + b >= 56)) begin
          bval = bit_len[8*(63-(4*i+b)) +: 8];
        end
        w_fill[i][8*(3-b) +: 8] = bval;
      end
    end
  end

  always_comb begin
    priority if (rnd_r < sha1_pkg::RoundW'(20)) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1_pkg::K_0;
    end else if (rnd_r < sha1_pkg::RoundW'(40)) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K_1;
    end else if (rnd_r < sha1_pkg::RoundW'(60)) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1_pkg::K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_pkg::K_3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_r[0];
  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // message schedule window: w_r[0] is the word of the current round
  always_ff @(posedge clk) begin
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end else if (cmd.byte_wr || cmd.pad || cmd.len_blk) begin
      w_r <= w_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha1_pkg::H_INIT;
      count_r <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.restart) begin
        chain_r <= sha1_pkg::H_INIT;
        count_r <= '0;
      end else begin
        if (cmd.fold) begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
        end
        if (cmd.byte_wr) begin
          count_r <= count_r + sha1_pkg::CountW'(1);
        end
      end
      if (cmd.start) begin
        rnd_r <= '0;
      end else if (cmd.round) begin
        rnd_r <= rnd_r + sha1_pkg::RoundW'(1);
      end
      if (cmd.restart) begin
        idx_r <= '0;
      end else if (cmd.emit_next) begin
        idx_r <= idx_r + sha1_pkg::IdxW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sha1_stream_hasher.sv */
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-------------------------------------
// in_      | request   | in_valid / in_stall | in_kind, in_data_byte
// out_     | result    | out_valid/out_stall | out_digest_word, out_last_word
//
// an append that completes a 64-byte block also compresses that block
// (load, 80 rounds at one round per cycle, chaining add)
// a finish compresses the padded block, plus a length-only block when the pad
// byte falls at offset 56 or later, then the five digest words, held while out_stall is high
// synchronous active-low reset brings back the initial chaining values
// in_stall stays high while a block is compressed and until the last digest word is taken
`default_nettype none
module sha1_stream_hasher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_last_word
);

  sha1_pkg::cmd_t cmd;
  sha1_pkg::sta_t sta;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .out_stall (out_stall),
    .sta       (sta),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  sha1_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .sta          (sta),
    .digest_word  (out_digest_word),
    .last_word    (out_last_word)
  );

endmodule
`default_nettype wire

/* rtl/core/sha1_stream_hasher_chk.sv */
`default_nettype none
module sha1_stream_hasher_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        in_kind,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_digest_word,
  input wire        out_last_word
);

  // a finish request always holds off the next request
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind) |=> in_stall)
    else $error("request taken straight after a finish");

  // no request is taken while a digest is being delivered
  a_emit_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during digest output");

  // the last word closes the digest
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> !out_valid)
    else $error("result after the last digest word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_digest_word) && $stable(out_last_word)))
    else $error("stalled result changed");

endmodule

bind sha1_stream_hasher sha1_stream_hasher_chk u_chk (.*);
`default_nettype wire

/* sim/sha1_stream_hasher_tb.sv */
`default_nettype none
module sha1_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_FINISH = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] CHAIN_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] ROUND_K0 = 32'h5A827999;
  localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_APPEND;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic        out_last_word;

  // predictor state
  logic [31:0] chain_q [5];
  logic [60:0] msg_bytes;
  logic [7:0]  blk_buf [64];

  digest_word_t expected_digest_words [$];
  int unsigned  err_count = 0;
  int unsigned  requests_sent = 0;
  int unsigned  stuck_cycles = 0;
  int unsigned  rx_hold = 0;
  logic         gaps_on = 1'b1;

  sha1_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_last_word   (out_last_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void restart_chain();
    for (int i = 0; i < 5; i++) chain_q[i] = CHAIN_IV[i];
    msg_bytes = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = ROUND_K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = ROUND_K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ROUND_K2;
      end else begin
        f = b ^ c ^ d;
        k = ROUND_K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endfunction

  // advance the hash state by one accepted request, queueing any digest words
  function automatic void hash_request(input req_kind_e kind, input logic [7:0] data);
    int unsigned pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    pos = msg_bytes[5:0];
    if (kind == KIND_APPEND) begin
      blk_buf[pos] = data;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) fold_block();
    end else begin
      blk_buf[pos] = PAD_MARK;
      pos++;
      // no room left for the length field, so it spills into an extra block
      if (pos > 56) begin
        while (pos < 64) begin
          blk_buf[pos] = 8'h00;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[8*(7-i) +: 8];
      fold_block();
      for (int i = 0; i < 5; i++) begin
        dw.word = chain_q[i];
        dw.last = (i == 4);
        expected_digest_words.push_back(dw);
      end
      restart_chain();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (!gaps_on || r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_request(input req_kind_e kind, input logic [7:0] data);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    hash_request(kind, data);
    requests_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_request(KIND_APPEND, 8'($urandom));
    send_request(KIND_FINISH, 8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_digest_words.size() != 0) @(posedge clk);
  endtask

  // lengths that put the pad byte either side of the length field or block boundary, mixed with random lengths
  function automatic int unsigned pick_length();
    int unsigned edges [11] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 12);
    if (r < 8) return edges[$urandom_range(0, 10)];
    return $urandom_range(0, 130);
  endfunction

  task automatic test_empty_message();
    send_request(KIND_FINISH, 8'h00);
    send_request(KIND_FINISH, 8'hFF);
  endtask

  task automatic test_byte_extremes();
    logic [7:0] pattern [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    foreach (pattern[i]) send_request(KIND_APPEND, pattern[i]);
    send_request(KIND_FINISH, 8'h5A);
    send_request(KIND_APPEND, 8'hFF);
    send_request(KIND_FINISH, 8'hA5);
  endtask

  task automatic test_random_messages(input int unsigned budget);
    int unsigned start;
    start = requests_sent;
    while (requests_sent - start < budget) begin
      // now and then the sender holds off until every digest word is back
      if ($urandom_range(0, 4) == 0) drain_results();
      send_message(pick_length());
    end
  endtask

  task automatic test_full_rate(input int unsigned budget);
    int unsigned start;
    drain_results();
    gaps_on <= 1'b0;
    start = requests_sent;
    while (requests_sent - start < budget) send_message(pick_length());
  endtask

  always @(posedge clk) begin
    if (!gaps_on) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_hold   <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digest_words.size() == 0) begin
        report_mismatch($sformatf("digest word %h with nothing expected", out_digest_word));
      end else begin
        want = expected_digest_words.pop_front();
        if (out_digest_word !== want.word)
          report_mismatch($sformatf("digest word %h, want %h", out_digest_word, want.word));
        if (out_last_word !== want.last)
          report_mismatch($sformatf("last flag %b, want %b", out_last_word, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
      $display("watchdog: no request or digest word moved for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    restart_chain();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_message();
    test_byte_extremes();
    test_random_messages(190);
    test_full_rate(85);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
